>>> rtl/gyro_ema_slew_limiter_assert.svh
// assertion macros shared by the gyro smoother rtl
`ifndef GYRO_EMA_SLEW_LIMITER_ASSERT_SVH
`define GYRO_EMA_SLEW_LIMITER_ASSERT_SVH

// checked only outside reset
`define GESL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gesl assertion failed");

// checked through reset as well
`define GESL_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gesl reset assertion failed");

`endif

>>> rtl/gesl_pkg.sv
// package: payload types, config codes and constants for the gyro smoother
package gesl_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned STATE_W    = 32;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned BUF_CNT_W  = 2;

  localparam logic [WEIGHT_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'h10000;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 31'h7FFF_FFFF;
  localparam logic [BUF_CNT_W-1:0] BUF_DEPTH   = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTHING_WEIGHT = 1'b0,
    REG_STEP_LIMIT       = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] rate_x;
    logic signed [SAMPLE_W-1:0] rate_y;
    logic signed [SAMPLE_W-1:0] rate_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] smooth_x;
    logic signed [SAMPLE_W-1:0] smooth_y;
    logic signed [SAMPLE_W-1:0] smooth_z;
  } out_item_t;

  // settings every lane sees
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [LIMIT_W-1:0]  limit;
  } lane_cfg_t;

endpackage

>>> rtl/gesl_lane.sv
// one axis: ema blend, slew clamp and filter state register
`include "gyro_ema_slew_limiter_assert.svh"

module gesl_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  gesl_pkg::lane_cfg_t                  cfg,
  input  logic signed [gesl_pkg::SAMPLE_W-1:0] sample,
  output logic signed [gesl_pkg::SAMPLE_W-1:0] smooth
);

  logic signed [gesl_pkg::STATE_W-1:0]   filt_r;
  logic signed [gesl_pkg::STATE_W-1:0]   filt_nxt;
  logic signed [gesl_pkg::STATE_W-1:0]   samp_q;
  logic signed [gesl_pkg::STATE_W:0]     diff;
  logic signed [gesl_pkg::STATE_W+gesl_pkg::WEIGHT_W+1:0] prod;
  logic signed [gesl_pkg::STATE_W:0]     blend;
  logic signed [gesl_pkg::STATE_W:0]     lim_pos;
  logic signed [gesl_pkg::STATE_W:0]     lim_neg;
  logic signed [gesl_pkg::STATE_W:0]     step;
  logic signed [gesl_pkg::STATE_W:0]     sum;
  logic signed [gesl_pkg::STATE_W-1:0]   rnd;

  assign samp_q = {sample, {gesl_pkg::FRAC_W{1'b0}}};
  assign diff   = {samp_q[gesl_pkg::STATE_W-1], samp_q} - {filt_r[gesl_pkg::STATE_W-1], filt_r};
  // weight at most one, so the scaled difference never outgrows diff
  assign prod   = diff * $signed({1'b0, cfg.weight});
  assign blend  = prod[gesl_pkg::STATE_W+gesl_pkg::FRAC_W:gesl_pkg::FRAC_W];

  assign lim_pos = {2'b00, cfg.limit};
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (blend > lim_pos) begin
      step = lim_pos;
    end else if (blend < lim_neg) begin
      step = lim_neg;
    end else begin
      step = blend;
    end
  end

  assign sum      = {filt_r[gesl_pkg::STATE_W-1], filt_r} + step;
  assign filt_nxt = sum[gesl_pkg::STATE_W-1:0];

  // truncate toward zero: bias negatives by one lsb short of an integer
  assign rnd    = filt_nxt + (filt_nxt[gesl_pkg::STATE_W-1] ? 32'sh0000_FFFF : 32'sh0);
  assign smooth = rnd[gesl_pkg::STATE_W-1:gesl_pkg::FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r <= '0;
    end else if (accept) begin
      filt_r <= filt_nxt;
    end
  end

  `GESL_ASSERT(a_hold_when_idle, !accept |=> $stable(filt_r))
  `GESL_ASSERT(a_zero_limit_holds, (accept && (cfg.limit == '0)) |=> $stable(filt_r))
  `GESL_ASSERT_RST(a_reset_clears, !rst_n |=> (filt_r == '0))

endmodule

>>> rtl/gesl_out_buf.sv
// merge of the lane results and a two-entry output buffer
`include "gyro_ema_slew_limiter_assert.svh"

module gesl_out_buf (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  logic signed [gesl_pkg::SAMPLE_W-1:0] lane_x,
  input  logic signed [gesl_pkg::SAMPLE_W-1:0] lane_y,
  input  logic signed [gesl_pkg::SAMPLE_W-1:0] lane_z,
  output logic                                 full,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output gesl_pkg::out_item_t                  out_data
);

  gesl_pkg::out_item_t              merged;
  gesl_pkg::out_item_t              slot0_r;
  gesl_pkg::out_item_t              slot1_r;
  logic [gesl_pkg::BUF_CNT_W-1:0]   count_r;
  logic                             pop;

  always_comb begin
    merged.smooth_x = lane_x;
    merged.smooth_y = lane_y;
    merged.smooth_z = lane_z;
  end

  assign full      = (count_r == gesl_pkg::BUF_DEPTH);
  assign out_valid = (count_r != '0);
  assign out_data  = slot0_r;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // slot0 is the head; the second slot only fills while the head is stalled
  always_ff @(posedge clk) begin
    unique case ({push, pop})
      2'b11: begin
        if (count_r == 2'd1) begin
          slot0_r <= merged;
        end else begin
          slot0_r <= slot1_r;
          slot1_r <= merged;
        end
      end
      2'b10: begin
        if (count_r == '0) begin
          slot0_r <= merged;
        end else begin
          slot1_r <= merged;
        end
      end
      2'b01: begin
        slot0_r <= slot1_r;
      end
      default: begin
        slot0_r <= slot0_r;
      end
    endcase
  end

  `GESL_ASSERT(a_count_bound, count_r <= gesl_pkg::BUF_DEPTH)
  `GESL_ASSERT(a_push_counts, (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
  `GESL_ASSERT_RST(a_reset_empty, !rst_n |=> (count_r == '0))

endmodule

>>> rtl/gyro_ema_slew_limiter.sv
// top level: config registers, three axis lanes and the output buffer
//
// Usage: one transfer on the in_ channel carries one raw gyro sample per
// axis (rate_x, rate_y, rate_z). Each axis runs its own lane that blends the
// sample into its Q16.16 filter state with smoothing_weight and limits the
// change to step_limit; the three lane results are merged into one out_
// item per input transfer.
// Output: results are registered in the output buffer and leave in order.
// Throughput: one item per cycle while the buffer is not full, through the
// multiply-clamp-update loop on each lane's filter register.
// Stall: a two-entry output buffer sits behind the lanes, so an input is
// taken while a result still waits; in_stall rises only when both entries
// are held by a stalled receiver.
// Reset (rst_n low, synchronous): filter state clears to zero, the buffer
// empties, smoothing_weight returns to 1.0 and step_limit to its maximum.
// Config: cfg_we with cfg_index and cfg_wdata writes one register in a cycle;
// the user must write only while no transfer is in flight; the block does not check.

module gyro_ema_slew_limiter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gesl_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output gesl_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [gesl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gesl_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [gesl_pkg::WEIGHT_W-1:0]        weight_r;
  logic [gesl_pkg::LIMIT_W-1:0]         limit_r;
  gesl_pkg::lane_cfg_t                  lane_cfg;
  logic                                 accept;
  logic                                 buf_full;
  logic signed [gesl_pkg::SAMPLE_W-1:0] lane_x;
  logic signed [gesl_pkg::SAMPLE_W-1:0] lane_y;
  logic signed [gesl_pkg::SAMPLE_W-1:0] lane_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= gesl_pkg::WEIGHT_RESET;
      limit_r  <= gesl_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (gesl_pkg::cfg_reg_t'(cfg_index))
        gesl_pkg::REG_SMOOTHING_WEIGHT: weight_r <= cfg_wdata[gesl_pkg::WEIGHT_W-1:0];
        gesl_pkg::REG_STEP_LIMIT:       limit_r  <= cfg_wdata[gesl_pkg::LIMIT_W-1:0];
        default:                        weight_r <= weight_r;
      endcase
    end
  end

  // weights above one saturate to one
  assign lane_cfg.weight = (weight_r > gesl_pkg::ONE_Q16) ? gesl_pkg::ONE_Q16 : weight_r;
  assign lane_cfg.limit  = limit_r;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  gesl_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cfg    (lane_cfg),
    .sample (in_data.rate_x),
    .smooth (lane_x)
  );

  gesl_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cfg    (lane_cfg),
    .sample (in_data.rate_y),
    .smooth (lane_y)
  );

  gesl_lane u_lane_z (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .cfg    (lane_cfg),
    .sample (in_data.rate_z),
    .smooth (lane_z)
  );

  gesl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .lane_x    (lane_x),
    .lane_y    (lane_y),
    .lane_z    (lane_z),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> bench/tb_gyro_ema_slew_limiter.sv
// testbench for the three-axis gyro smoother with slew-rate limit
module tb_gyro_ema_slew_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 212;

  // predicts the filtered axes and checks each result transfer against them
  class gyro_smooth_scoreboard;
    logic [gesl_pkg::WEIGHT_W-1:0] weight;
    logic [gesl_pkg::LIMIT_W-1:0]  limit;
    int                            filt_state [gesl_pkg::AXES];
    gesl_pkg::out_item_t           smooth_expected [$];
    int                            failures;

    function new();
      weight = gesl_pkg::WEIGHT_RESET;
      limit = gesl_pkg::LIMIT_RESET;
      foreach (filt_state[i]) filt_state[i] = 0;
      failures = 0;
    endfunction

    function void write_reg(gesl_pkg::cfg_reg_t idx,
                            logic [gesl_pkg::CFG_DATA_W-1:0] value);
      if (idx == gesl_pkg::REG_SMOOTHING_WEIGHT)
        weight = value[gesl_pkg::WEIGHT_W-1:0];
      else if (idx == gesl_pkg::REG_STEP_LIMIT)
        limit = value[gesl_pkg::LIMIT_W-1:0];
    endfunction

    // one axis: blend the sample in, then clamp the move to the step limit
    function int blend_and_limit(int prev, logic signed [gesl_pkg::SAMPLE_W-1:0] raw);
      longint w, s, p, lim, e, d, n;
      w = (weight > gesl_pkg::ONE_Q16) ? longint'(gesl_pkg::ONE_Q16) : longint'(weight);
      s = longint'(raw) * 65536;
      p = longint'(prev);
      lim = {33'b0, limit};
      e = (w * s + (65536 - w) * p) >>> gesl_pkg::FRAC_W;
      d = e - p;
      if (d > lim)
        n = p + lim;
      else if (d < -lim)
        n = p - lim;
      else
        n = e;
      return int'(n);
    endfunction

    function logic signed [gesl_pkg::SAMPLE_W-1:0] whole_part(int v);
      longint x, o;
      x = longint'(v);
      o = (x >= 0) ? (x >>> gesl_pkg::FRAC_W) : -((-x) >>> gesl_pkg::FRAC_W);
      return o[gesl_pkg::SAMPLE_W-1:0];
    endfunction

    function void note_sample(gesl_pkg::in_item_t s);
      gesl_pkg::out_item_t e;
      filt_state[0] = blend_and_limit(filt_state[0], s.rate_x);
      filt_state[1] = blend_and_limit(filt_state[1], s.rate_y);
      filt_state[2] = blend_and_limit(filt_state[2], s.rate_z);
      e.smooth_x = whole_part(filt_state[0]);
      e.smooth_y = whole_part(filt_state[1]);
      e.smooth_z = whole_part(filt_state[2]);
      smooth_expected.push_back(e);
    endfunction

    function void check_result(gesl_pkg::out_item_t got);
      gesl_pkg::out_item_t e;
      if (smooth_expected.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result transfer: %0d %0d %0d",
                   got.smooth_x, got.smooth_y, got.smooth_z);
        return;
      end
      e = smooth_expected.pop_front();
      if (got.smooth_x !== e.smooth_x || got.smooth_y !== e.smooth_y ||
          got.smooth_z !== e.smooth_z) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                   e.smooth_x, e.smooth_y, e.smooth_z,
                   got.smooth_x, got.smooth_y, got.smooth_z);
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  gesl_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  gesl_pkg::out_item_t             out_data;
  logic                            cfg_we = 1'b0;
  logic [gesl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [gesl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  gyro_smooth_scoreboard smooth_sb = new();
  bit                    in_burst = 1'b0;
  bit                    out_burst = 1'b0;
  int                    idle_cycles = 0;

  gyro_ema_slew_limiter i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        smooth_sb.note_sample(in_data);
      if (out_valid && !out_stall)
        smooth_sb.check_result(out_data);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[gyro_ema_slew_limiter] ERROR");
      $finish;
    end
  end

  // receiver: random stall before each result
  initial begin
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic push_sample(gesl_pkg::in_item_t s);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_rates(int x, int y, int z);
    gesl_pkg::in_item_t s;
    s.rate_x = x[gesl_pkg::SAMPLE_W-1:0];
    s.rate_y = y[gesl_pkg::SAMPLE_W-1:0];
    s.rate_z = z[gesl_pkg::SAMPLE_W-1:0];
    push_sample(s);
  endtask

  // wait until every expected result has come out, then let the pipe settle
  // the first edge lets the monitor note a transfer taken at the current one
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (smooth_sb.smooth_expected.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_register(gesl_pkg::cfg_reg_t idx,
                              logic [gesl_pkg::CFG_DATA_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    smooth_sb.write_reg(idx, value);
  endtask

  function automatic logic [gesl_pkg::SAMPLE_W-1:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 128) - 64);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [gesl_pkg::CFG_DATA_W-1:0] pick_weight();
    logic [gesl_pkg::WEIGHT_W-1:0] w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = 17'd1;
      2: w = 17'hFFFF;
      3: w = gesl_pkg::ONE_Q16;
      4: w = 17'h1FFFF;
      default: w = 17'($urandom_range(0, 65536));
    endcase
    // upper bits beyond the register are don't-care on the write
    return {14'($urandom()), w};
  endfunction

  function automatic logic [gesl_pkg::CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 31'd1;
      2: return gesl_pkg::LIMIT_RESET;
      3: return 31'($urandom_range(0, 65536 * 16));
      4, 5: return 31'($urandom_range(0, 65536 * 4096));
      default: return 31'($urandom());
    endcase
  endfunction

  initial begin
    gesl_pkg::in_item_t s;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: straight pass-through, full-scale swings
    send_rates(32767, -32768, 0);
    send_rates(-32768, 32767, -1);
    send_rates(1, -1, 0);
    send_rates(32767, 32767, 32767);
    send_rates(-32768, -32768, -32768);
    // zero weight holds the state
    set_register(gesl_pkg::REG_SMOOTHING_WEIGHT, '0);
    send_rates(32767, 0, 1234);
    send_rates(-32768, 5, -1234);
    // weight above one saturates, upper data bits dropped
    set_register(gesl_pkg::REG_SMOOTHING_WEIGHT, 31'h7FFF_FFFF);
    send_rates(100, -200, 32767);
    set_register(gesl_pkg::REG_SMOOTHING_WEIGHT, 31'h7FFE_0000 | 31'h1_0001);
    send_rates(-32768, 32767, 7);
    // half weight: negative fractions truncate toward zero
    set_register(gesl_pkg::REG_SMOOTHING_WEIGHT, 31'h8000);
    send_rates(-1, 1, -3);
    send_rates(-1, 2, -32768);
    // zero step limit freezes the state
    set_register(gesl_pkg::REG_STEP_LIMIT, '0);
    send_rates(32767, -32768, 0);
    send_rates(-32768, 32767, 1);
    // smallest step
    set_register(gesl_pkg::REG_SMOOTHING_WEIGHT, 31'h1_0000);
    set_register(gesl_pkg::REG_STEP_LIMIT, 31'd1);
    send_rates(32767, -32768, 0);
    send_rates(-32768, 32767, 3);
    // one whole count per sample
    set_register(gesl_pkg::REG_STEP_LIMIT, 31'h1_0000);
    send_rates(32767, -32768, 10);
    send_rates(32767, -32768, -10);
    send_rates(-5, 5, 0);
    // tiny weight with the limit open again
    set_register(gesl_pkg::REG_STEP_LIMIT, gesl_pkg::LIMIT_RESET);
    set_register(gesl_pkg::REG_SMOOTHING_WEIGHT, 31'd1);
    send_rates(-32768, 32767, -1);
    send_rates(32767, -32768, 1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_register(gesl_pkg::REG_SMOOTHING_WEIGHT, pick_weight());
      set_register(gesl_pkg::REG_STEP_LIMIT, pick_limit());
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        s.rate_x = pick_rate();
        s.rate_y = pick_rate();
        s.rate_z = pick_rate();
        push_sample(s);
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (smooth_sb.smooth_expected.size() != 0) begin
      smooth_sb.failures++;
      $display("%0d results never arrived", smooth_sb.smooth_expected.size());
    end
    if (smooth_sb.failures == 0)
      $display("[gyro_ema_slew_limiter] OK");
    else
      $display("[gyro_ema_slew_limiter] ERROR");
    $finish;
  end

endmodule
